### hdl/bpa_pkg.sv
`timescale 1ns / 1ps
package bpa_pkg;

   localparam int NUM_PAGES          = 4096;
   localparam int MAX_RUN            = 32;
   localparam int RESERVED_TOP_PAGES = 256;
   localparam int PAGE_SHIFT         = 12;

   localparam int PAGE_W = $clog2(NUM_PAGES);
   localparam int SIZE_W = 17;
   localparam int CNT_W  = 6;
   localparam int STAT_W = 2;
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   localparam int TOP_PAGE = (NUM_PAGES > RESERVED_TOP_PAGES) ?
                             (NUM_PAGES - RESERVED_TOP_PAGES) : 0;

   localparam logic [PAGE_W-1:0] FIRST_USABLE_RESET = PAGE_W'(256);

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
   localparam logic [STAT_W-1:0] ST_NO_RUN   = 2'd1;
   localparam logic [STAT_W-1:0] ST_NO_FRAME = 2'd2;
   localparam logic [STAT_W-1:0] ST_PRESENT  = 2'd3;

   localparam logic [CSR_AW-3:0] REG_FIRST_USABLE = '0;

   typedef struct packed {
      logic              cmd;
      logic [CNT_W-1:0]  count;
      logic [PAGE_W-1:0] page;
   } bpa_job_type;

   typedef struct packed {
      logic              present;
      logic [PAGE_W-1:0] frame;
   } bpa_entry_type;

endpackage

### hdl/bpa_if.sv
`timescale 1ns / 1ps
interface bpa_req_if import bpa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              cmd;
   logic [SIZE_W-1:0] size_bytes;
   logic [PAGE_W-1:0] page_number;
   modport source (output valid, cmd, size_bytes, page_number, input ready);
   modport sink   (input valid, cmd, size_bytes, page_number, output ready);
endinterface

interface bpa_rsp_if import bpa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status;
   logic [PAGE_W-1:0] first_page;
   logic [CNT_W-1:0]  pages_done;
   modport source (output valid, status, first_page, pages_done, input ready);
   modport sink   (input valid, status, first_page, pages_done, output ready);
endinterface

### hdl/bpa_front.sv
`timescale 1ns / 1ps
module bpa_front import bpa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   bpa_req_if.sink     req,
   output logic        job_valid,
   output bpa_job_type job,
   input  logic        job_pop
);

   bpa_job_type slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  fill_ff, fill_in;
   logic        push;
   logic        pop;
   bpa_job_type incoming;

   assign req.ready = (fill_ff != 2'd2);
   assign push      = req.valid && req.ready;
   assign pop       = job_pop && (fill_ff != 2'd0);
   assign job_valid = (fill_ff != 2'd0);
   assign job       = slot_ff[rd_ptr_ff];

   always_comb begin
      incoming.cmd   = req.cmd;
      // page count: whole pages in the size plus one
      incoming.count = CNT_W'(req.size_bytes >> PAGE_SHIFT) + CNT_W'(1);
      incoming.page  = req.page_number;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= incoming;
      end
   end

endmodule

### hdl/bpa_engine.sv
`timescale 1ns / 1ps
module bpa_engine import bpa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [PAGE_W-1:0] first_usable,
   input  logic              job_valid,
   input  bpa_job_type       job,
   output logic              job_pop,
   bpa_rsp_if.source         rsp
);

   localparam logic [2:0] S_CLR   = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_RUN   = 3'd2;
   localparam logic [2:0] S_FRAME = 3'd3;
   localparam logic [2:0] S_FRD   = 3'd4;
   localparam logic [2:0] S_FWR   = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   localparam logic [PAGE_W:0] NUM_C = (PAGE_W+1)'(NUM_PAGES);
   localparam logic [PAGE_W:0] TOP_C = (PAGE_W+1)'(TOP_PAGE);

   logic vmap [NUM_PAGES];
   logic fmap [NUM_PAGES];
   bpa_entry_type tmap [NUM_PAGES];

   logic          v_rd_ff, f_rd_ff;
   bpa_entry_type t_rd_ff;

   logic [2:0]        state_ff, state_in;
   logic [PAGE_W:0]   scan_ff, scan_in;
   logic              pv_ff, pv_in;
   logic [PAGE_W-1:0] pidx_ff, pidx_in;
   logic [CNT_W-1:0]  len_ff, len_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic [PAGE_W:0]   vcur_ff, vcur_in;
   logic [PAGE_W-1:0] start_ff, start_in;
   logic [STAT_W-1:0] stat_ff, stat_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0] rsp_status_ff;
   logic [PAGE_W-1:0] rsp_first_ff;
   logic [CNT_W-1:0]  rsp_done_ff;
   logic              rsp_load;

   logic              vwe, fwe, twe;
   logic [PAGE_W-1:0] vwa, fwa, twa;
   logic              vwd, fwd;
   bpa_entry_type     twd;
   logic              p_used, f_used, issue;

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.status     = rsp_status_ff;
   assign rsp.first_page = rsp_first_ff;
   assign rsp.pages_done = rsp_done_ff;

   assign issue  = (scan_ff < NUM_C);
   assign p_used = (pidx_ff < first_usable) || v_rd_ff;
   assign f_used = (pidx_ff < first_usable) || f_rd_ff;

   always_comb begin
      state_in = state_ff;
      scan_in  = scan_ff;
      pv_in    = 1'b0;
      pidx_in  = pidx_ff;
      len_in   = len_ff;
      cnt_in   = cnt_ff;
      k_in     = k_ff;
      vcur_in  = vcur_ff;
      start_in = start_ff;
      stat_in  = stat_ff;
      job_pop  = 1'b0;
      rsp_load = 1'b0;
      vwe = 1'b0; vwa = scan_ff[PAGE_W-1:0]; vwd = 1'b0;
      fwe = 1'b0; fwa = scan_ff[PAGE_W-1:0]; fwd = 1'b0;
      twe = 1'b0; twa = scan_ff[PAGE_W-1:0]; twd = '0;

      case (state_ff)
         S_CLR: begin
            // sweep after reset: reserved top pages used, table empty
            vwe = 1'b1; vwd = (scan_ff >= TOP_C);
            fwe = 1'b1; fwd = (scan_ff >= TOP_C);
            twe = 1'b1;
            scan_in = scan_ff + 1'b1;
            if (scan_ff == NUM_C - 1'b1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               cnt_in   = job.count;
               k_in     = '0;
               stat_in  = ST_OK;
               scan_in  = '0;
               len_in   = '0;
               start_in = '0;
               if (job.cmd == CMD_FREE) begin
                  vcur_in  = {1'b0, job.page};
                  state_in = S_FRD;
               end else if (32'(job.count) > MAX_RUN) begin
                  stat_in  = ST_NO_RUN;
                  state_in = S_DONE;
               end else begin
                  state_in = S_RUN;
               end
            end
         end
         S_RUN: begin
            pv_in   = issue;
            pidx_in = scan_ff[PAGE_W-1:0];
            if (issue) begin
               scan_in = scan_ff + 1'b1;
            end
            if (pv_ff) begin
               len_in = p_used ? '0 : len_ff + 1'b1;
               if (!p_used && (len_ff + 1'b1 == cnt_ff)) begin
                  start_in = pidx_ff + PAGE_W'(1) - PAGE_W'(cnt_ff);
                  vcur_in  = {1'b0, pidx_ff + PAGE_W'(1) - PAGE_W'(cnt_ff)};
                  scan_in  = '0;
                  pv_in    = 1'b0;
                  state_in = S_FRAME;
               end
            end else if (!issue) begin
               stat_in  = ST_NO_RUN;
               state_in = S_DONE;
            end
         end
         S_FRAME: begin
            pv_in   = issue;
            pidx_in = scan_ff[PAGE_W-1:0];
            if (issue) begin
               scan_in = scan_ff + 1'b1;
            end
            if (pv_ff) begin
               if (!f_used) begin
                  pv_in = 1'b0;
                  if (t_rd_ff.present) begin
                     stat_in  = ST_PRESENT;
                     state_in = S_DONE;
                  end else begin
                     vwe = 1'b1; vwa = vcur_ff[PAGE_W-1:0]; vwd = 1'b1;
                     fwe = 1'b1; fwa = pidx_ff;              fwd = 1'b1;
                     twe = 1'b1; twa = vcur_ff[PAGE_W-1:0];
                     twd.present = 1'b1;
                     twd.frame   = pidx_ff;
                     k_in    = k_ff + 1'b1;
                     vcur_in = vcur_ff + 1'b1;
                     // frames below this one are known used
                     scan_in = {1'b0, pidx_ff} + 1'b1;
                     if (k_ff + 1'b1 == cnt_ff) begin
                        state_in = S_DONE;
                     end
                  end
               end
            end else if (!issue) begin
               stat_in  = ST_NO_FRAME;
               state_in = S_DONE;
            end
         end
         S_FRD: begin
            if (vcur_ff >= NUM_C) begin
               state_in = S_DONE;
            end else begin
               state_in = S_FWR;
            end
         end
         S_FWR: begin
            vwe = 1'b1; vwa = vcur_ff[PAGE_W-1:0]; vwd = 1'b0;
            fwe = 1'b1; fwa = t_rd_ff.frame;       fwd = 1'b0;
            twe = 1'b1; twa = vcur_ff[PAGE_W-1:0];
            k_in    = k_ff + 1'b1;
            vcur_in = vcur_ff + 1'b1;
            state_in = (k_ff + 1'b1 == cnt_ff) ? S_DONE : S_FRD;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         scan_ff      <= '0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff  <= pidx_in;
      len_ff   <= len_in;
      cnt_ff   <= cnt_in;
      k_ff     <= k_in;
      vcur_ff  <= vcur_in;
      start_ff <= start_in;
      stat_ff  <= stat_in;
      if (rsp_load) begin
         rsp_status_ff <= stat_ff;
         rsp_first_ff  <= (stat_ff == ST_OK && cnt_ff != 0 && vwe == 1'b0 &&
                           state_ff == S_DONE && k_ff == cnt_ff &&
                           !job_pop) ? start_ff : '0;
         rsp_done_ff   <= k_ff;
      end
   end

   // bitmaps and page table, one write and one registered read each
   always_ff @(posedge clock) begin
      if (vwe) begin
         vmap[vwa] <= vwd;
      end
      v_rd_ff <= vmap[scan_ff[PAGE_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (fwe) begin
         fmap[fwa] <= fwd;
      end
      f_rd_ff <= fmap[scan_ff[PAGE_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (twe) begin
         tmap[twa] <= twd;
      end
      t_rd_ff <= tmap[vcur_ff[PAGE_W-1:0]];
   end

endmodule

### hdl/bitmap_page_allocator.sv
`timescale 1ns / 1ps
// Page allocator over a virtual-page bitmap, a frame bitmap and a page table.
// A request is queued by the front end (two deep) and carried out by a
// sequencer that scans the bitmaps one bit per cycle through registered
// memory reads. Allocate first scans the virtual bitmap for a free run,
// then, per page, scans the frame bitmap on to the next free frame; free
// reads each page's entry and then clears it and its bitmap bits. Each
// request also has one step to take it from the queue and one to hand the answer over.
// After reset a clearing pass over all 4096 pages initialises the memories;
// requests queue but are not served until it ends. The one register,
// first_usable_page, sits at byte address 0.
module bitmap_page_allocator import bpa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   bpa_req_if.sink           req_bus,
   bpa_rsp_if.source         rsp_bus,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   logic [PAGE_W-1:0] first_usable_ff, first_usable_in;
   logic              csr_wr;
   logic              job_valid;
   logic              job_pop;
   bpa_job_type       job;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[CSR_AW-1:2] == REG_FIRST_USABLE);
   assign csr_prdata = (csr_paddr[CSR_AW-1:2] == REG_FIRST_USABLE) ?
                       CSR_DW'(first_usable_ff) : '0;

   always_comb begin
      first_usable_in = csr_wr ? csr_pwdata[PAGE_W-1:0] : first_usable_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_usable_ff <= FIRST_USABLE_RESET;
      end else begin
         first_usable_ff <= first_usable_in;
      end
   end

   bpa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .job_valid (job_valid),
      .job       (job),
      .job_pop   (job_pop)
   );

   bpa_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .first_usable (first_usable_ff),
      .job_valid    (job_valid),
      .job          (job),
      .job_pop      (job_pop),
      .rsp          (rsp_bus)
   );

endmodule
